>>> sv/itf_pkg.sv
`timescale 1ns / 1ps
// itf_pkg: shared constants, codes and controller/datapath handshake types
// for the integer-to-text field formatter; no dependencies

package itf_pkg;

  localparam int DIGIT_BUFFER_DEPTH = 34;
  localparam int MAX_FIELD_WIDTH    = 64;

  localparam int CMD_W = 3;
  localparam int VAL_W = 32;
  localparam int FW_W  = 7;
  localparam int DIG_W = 4;
  localparam int CHR_W = 8;
  localparam int ND_W  = $clog2(DIGIT_BUFFER_DEPTH + 1);

  // conversion kinds
  localparam logic [CMD_W-1:0] CMD_SDEC = 3'd0;
  localparam logic [CMD_W-1:0] CMD_UDEC = 3'd1;
  localparam logic [CMD_W-1:0] CMD_HEXL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_HEXU = 3'd3;
  localparam logic [CMD_W-1:0] CMD_BIN  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PTR  = 3'd5;

  // digit extraction radix
  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_HEX = 2'd1;
  localparam logic [1:0] RADIX_BIN = 2'd2;

  // ceil(2^35 / 10): floor(v * RECIP10 / 2^35) == v / 10 for any 32-bit v
  localparam logic [VAL_W-1:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int               RECIP_SHIFT = 35;

  localparam logic [CHR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHR_W-1:0] CH_LB    = 8'h62;
  localparam logic [CHR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHR_W-1:0] CH_UA    = 8'h41;

  typedef struct packed {
    logic load;
    logic extract;
    logic plan;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic extract_done;
    logic emit_last;
    logic out_free;
  } ctrl_sts_t;

  function automatic logic [CHR_W-1:0] digit_char(input logic [DIG_W-1:0] d,
                                                  input logic upper);
    logic [CHR_W-1:0] base;
    base = upper ? CH_UA : CH_LA;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {4'd0, d};
    end else begin
      digit_char = base + {4'd0, d} - 8'd10;
    end
  endfunction

endpackage

>>> sv/itf_in_if.sv
`timescale 1ns / 1ps
// itf_in_if: input channel of the formatter, valid/ready plus one value
// with its conversion kind, flags and field width; uses itf_pkg

interface itf_in_if;
  logic                           valid;
  logic                           ready;
  logic [itf_pkg::CMD_W-1:0]      cmd;
  logic [itf_pkg::VAL_W-1:0]      value;
  logic                           zero_fill;
  logic                           left_justify;
  logic                           space_for_plus;
  logic                           force_plus;
  logic                           radix_prefix;
  logic [itf_pkg::FW_W-1:0]       field_width;

  modport source (output valid, cmd, value, zero_fill, left_justify, space_for_plus,
                  force_plus, radix_prefix, field_width, input ready);
  modport sink (input valid, cmd, value, zero_fill, left_justify, space_for_plus,
                force_plus, radix_prefix, field_width, output ready);
endinterface

>>> sv/itf_out_if.sv
`timescale 1ns / 1ps
// itf_out_if: result channel of the formatter, valid/ready plus one text
// character, end-of-field mark and field length; uses itf_pkg

interface itf_out_if;
  logic                           valid;
  logic                           ready;
  logic [itf_pkg::CHR_W-1:0]      text_char;
  logic                           last;
  logic [itf_pkg::FW_W-1:0]       field_length;

  modport source (output valid, text_char, last, field_length, input ready);
  modport sink (input valid, text_char, last, field_length, output ready);
endinterface

>>> sv/itf_ctrl.sv
`timescale 1ns / 1ps
// itf_ctrl: sequencing state machine of the formatter (load, digit loop,
// field plan, character emission); uses itf_pkg command/status types

module itf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  itf_pkg::ctrl_sts_t sts,
  output itf_pkg::ctrl_cmd_t ctl
);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_EXTRACT = 4'b0010,
    ST_PLAN    = 4'b0100,
    ST_EMIT    = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    ctl         = '0;
    in_ready    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          ctl.load  = 1'b1;
          state_nxt = ST_EXTRACT;
        end
      end
      ST_EXTRACT: begin
        ctl.extract = 1'b1;
        if (sts.extract_done) begin
          state_nxt = ST_PLAN;
        end
      end
      ST_PLAN: begin
        ctl.plan  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          ctl.emit = 1'b1;
          if (sts.emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/itf_dp.sv
`timescale 1ns / 1ps
// itf_dp: formatter datapath: operand decode, digit extraction into a
// shift line, field layout and the registered output character; uses itf_pkg

module itf_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  itf_pkg::ctrl_cmd_t            ctl,
  output itf_pkg::ctrl_sts_t            sts,
  input  logic [itf_pkg::CMD_W-1:0]     in_cmd,
  input  logic [itf_pkg::VAL_W-1:0]     in_value,
  input  logic                          in_zero_fill,
  input  logic                          in_left_justify,
  input  logic                          in_space_for_plus,
  input  logic                          in_force_plus,
  input  logic                          in_radix_prefix,
  input  logic [itf_pkg::FW_W-1:0]      in_field_width,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [itf_pkg::CHR_W-1:0]     out_text_char,
  output logic                          out_last,
  output logic [itf_pkg::FW_W-1:0]      out_field_length
);

  localparam int D     = itf_pkg::DIGIT_BUFFER_DEPTH;
  localparam int FW_W  = itf_pkg::FW_W;
  localparam int VAL_W = itf_pkg::VAL_W;
  localparam int CHR_W = itf_pkg::CHR_W;
  localparam int DIG_W = itf_pkg::DIG_W;
  localparam int ND_W  = itf_pkg::ND_W;

  // operand and flags
  logic [1:0]        radix_r;
  logic              upper_r;
  logic              sign_en_r;
  logic [CHR_W-1:0]  sign_ch_r;
  logic              prefix_en_r;
  logic [CHR_W-1:0]  prefix_ch_r;
  logic              lj_r;
  logic              zf_r;
  logic [FW_W-1:0]   fw_r;
  logic [VAL_W-1:0]  val_r;
  logic [DIG_W-1:0]  dig_r [D];
  logic [ND_W-1:0]   nd_r;

  // field layout boundaries
  logic [FW_W-1:0]   b_lead_r, b_sign_r, b_prefix_r, b_zpad_r, b_digit_r, total_r;
  logic [FW_W-1:0]   k_r;

  logic              out_valid_r;
  logic [CHR_W-1:0]  out_char_r;
  logic              out_last_r;
  logic [FW_W-1:0]   out_len_r;

  // load decode
  logic [1:0]        ld_radix;
  logic              ld_upper, ld_signed_ok, ld_neg, ld_prefix, ld_sign_en;
  logic [CHR_W-1:0]  ld_prefix_ch, ld_sign_ch;
  logic [VAL_W-1:0]  ld_val;
  logic [FW_W-1:0]   ld_fw;

  always_comb begin
    ld_radix     = itf_pkg::RADIX_DEC;
    ld_upper     = 1'b0;
    ld_signed_ok = 1'b0;
    ld_neg       = 1'b0;
    ld_prefix    = 1'b0;
    ld_prefix_ch = itf_pkg::CH_LX;
    case (in_cmd)
      itf_pkg::CMD_SDEC: begin
        ld_signed_ok = 1'b1;
        ld_neg       = in_value[VAL_W-1];
      end
      itf_pkg::CMD_UDEC: begin
        ld_radix = itf_pkg::RADIX_DEC;
      end
      itf_pkg::CMD_HEXL: begin
        ld_radix  = itf_pkg::RADIX_HEX;
        ld_prefix = in_radix_prefix;
      end
      itf_pkg::CMD_HEXU: begin
        ld_radix  = itf_pkg::RADIX_HEX;
        ld_upper  = 1'b1;
        ld_prefix = in_radix_prefix;
      end
      itf_pkg::CMD_BIN: begin
        ld_radix     = itf_pkg::RADIX_BIN;
        ld_prefix    = in_radix_prefix;
        ld_prefix_ch = itf_pkg::CH_LB;
      end
      itf_pkg::CMD_PTR: begin
        ld_radix     = itf_pkg::RADIX_HEX;
        ld_prefix    = 1'b1;
        ld_signed_ok = 1'b1;
      end
      default: begin
        ld_radix = itf_pkg::RADIX_DEC;
      end
    endcase

    ld_val = ld_neg ? (32'd0 - in_value) : in_value;

    ld_sign_en = 1'b1;
    ld_sign_ch = itf_pkg::CH_MINUS;
    if (ld_neg) begin
      ld_sign_ch = itf_pkg::CH_MINUS;
    end else if (ld_signed_ok && in_force_plus) begin
      ld_sign_ch = itf_pkg::CH_PLUS;
    end else if (ld_signed_ok && in_space_for_plus) begin
      ld_sign_ch = itf_pkg::CH_SPACE;
    end else begin
      ld_sign_en = 1'b0;
    end

    ld_fw = (in_field_width > FW_W'(itf_pkg::MAX_FIELD_WIDTH)) ?
            FW_W'(itf_pkg::MAX_FIELD_WIDTH) : in_field_width;
  end

  // one digit per cycle, least significant first
  logic [2*VAL_W-1:0] prod;
  logic [VAL_W-1:0]   q_dec, q10, ext_quot;
  logic [DIG_W-1:0]   ext_digit;

  assign prod  = {{VAL_W{1'b0}}, val_r} * {{VAL_W{1'b0}}, itf_pkg::RECIP10};
  assign q_dec = VAL_W'(prod >> itf_pkg::RECIP_SHIFT);
  assign q10   = (q_dec << 3) + (q_dec << 1);

  always_comb begin
    case (radix_r)
      itf_pkg::RADIX_HEX: begin
        ext_digit = val_r[DIG_W-1:0];
        ext_quot  = val_r >> 4;
      end
      itf_pkg::RADIX_BIN: begin
        ext_digit = {3'd0, val_r[0]};
        ext_quot  = val_r >> 1;
      end
      default: begin
        ext_digit = val_r[DIG_W-1:0] - q10[DIG_W-1:0];
        ext_quot  = q_dec;
      end
    endcase
  end

  // field layout
  logic [FW_W-1:0] pl_body, pl_total, pl_pad, pl_lead, pl_zpad;
  logic [FW_W-1:0] pl_b_sign, pl_b_prefix, pl_b_zpad, pl_b_digit;

  always_comb begin
    pl_body     = FW_W'(nd_r) + FW_W'(sign_en_r) + (prefix_en_r ? 7'd2 : 7'd0);
    pl_total    = (fw_r > pl_body) ? fw_r : pl_body;
    pl_pad      = pl_total - pl_body;
    pl_lead     = (!lj_r && !zf_r) ? pl_pad : '0;
    pl_zpad     = (!lj_r && zf_r) ? pl_pad : '0;
    pl_b_sign   = pl_lead + FW_W'(sign_en_r);
    pl_b_prefix = pl_b_sign + (prefix_en_r ? 7'd2 : 7'd0);
    pl_b_zpad   = pl_b_prefix + pl_zpad;
    pl_b_digit  = pl_b_zpad + FW_W'(nd_r);
  end

  // character at position k_r
  logic [CHR_W-1:0] em_char;
  logic             em_is_digit, em_last;

  always_comb begin
    em_is_digit = 1'b0;
    if (k_r < b_lead_r) begin
      em_char = itf_pkg::CH_SPACE;
    end else if (k_r < b_sign_r) begin
      em_char = sign_ch_r;
    end else if (k_r < b_prefix_r) begin
      em_char = (k_r == b_sign_r) ? itf_pkg::CH_ZERO : prefix_ch_r;
    end else if (k_r < b_zpad_r) begin
      em_char = itf_pkg::CH_ZERO;
    end else if (k_r < b_digit_r) begin
      em_char     = itf_pkg::digit_char(dig_r[0], upper_r);
      em_is_digit = 1'b1;
    end else begin
      em_char = itf_pkg::CH_SPACE;
    end
    em_last = ((k_r + 7'd1) == total_r);
  end

  assign sts.extract_done = (ext_quot == '0);
  assign sts.emit_last    = em_last;
  assign sts.out_free     = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      radix_r     <= ld_radix;
      upper_r     <= ld_upper;
      sign_en_r   <= ld_sign_en;
      sign_ch_r   <= ld_sign_ch;
      prefix_en_r <= ld_prefix;
      prefix_ch_r <= ld_prefix_ch;
      lj_r        <= in_left_justify;
      zf_r        <= in_zero_fill;
      fw_r        <= ld_fw;
      val_r       <= ld_val;
      nd_r        <= '0;
    end else if (ctl.extract) begin
      val_r <= ext_quot;
      nd_r  <= nd_r + ND_W'(1);
    end

    if (ctl.extract) begin
      dig_r[0] <= ext_digit;
      for (int i = 1; i < D; i++) begin
        dig_r[i] <= dig_r[i-1];
      end
    end else if (ctl.emit && em_is_digit) begin
      for (int i = 0; i < D - 1; i++) begin
        dig_r[i] <= dig_r[i+1];
      end
      dig_r[D-1] <= '0;
    end

    if (ctl.plan) begin
      b_lead_r   <= pl_lead;
      b_sign_r   <= pl_b_sign;
      b_prefix_r <= pl_b_prefix;
      b_zpad_r   <= pl_b_zpad;
      b_digit_r  <= pl_b_digit;
      total_r    <= pl_total;
      k_r        <= '0;
    end else if (ctl.emit) begin
      k_r <= k_r + 7'd1;
    end

    if (ctl.emit) begin
      out_char_r <= em_char;
      out_last_r <= em_last;
      out_len_r  <= total_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_text_char    = out_char_r;
  assign out_last         = out_last_r;
  assign out_field_length = out_len_r;

endmodule

>>> sv/integer_to_text_field_formatter_top.sv
`timescale 1ns / 1ps
// integer_to_text_field_formatter_top: printf-style integer field formatter
// built from itf_ctrl and itf_dp; uses itf_pkg, itf_in_if and itf_out_if
//
// channel   direction  payload
// in_if     sink       cmd, value, zero_fill, left_justify, space_for_plus,
//                      force_plus, radix_prefix, field_width
// out_if    source     text_char, last, field_length (one per character)
//
// one transaction is a load step, then one digit per cycle (up to 10 decimal,
// 8 hex, 32 binary) through the divide-by-ten or shift unit, a layout step,
// then one output character per cycle while not stalled (field length, up to 64)
// a new input transaction is taken once the last character sits in the
// output register; output stalls hold the character loop
// rst_n is synchronous and clears the state machine and output valid

module integer_to_text_field_formatter_top (
  input logic        clk,
  input logic        rst_n,
  itf_in_if.sink     in_if,
  itf_out_if.source  out_if
);

  itf_pkg::ctrl_cmd_t ctl;
  itf_pkg::ctrl_sts_t sts;

  itf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  itf_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .sts               (sts),
    .in_cmd            (in_if.cmd),
    .in_value          (in_if.value),
    .in_zero_fill      (in_if.zero_fill),
    .in_left_justify   (in_if.left_justify),
    .in_space_for_plus (in_if.space_for_plus),
    .in_force_plus     (in_if.force_plus),
    .in_radix_prefix   (in_if.radix_prefix),
    .in_field_width    (in_if.field_width),
    .out_ready         (out_if.ready),
    .out_valid         (out_if.valid),
    .out_text_char     (out_if.text_char),
    .out_last          (out_if.last),
    .out_field_length  (out_if.field_length)
  );

endmodule
